FILE: rtl/crtlo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crtlo_pkg
// Types, constants and small lookup functions shared by the CRT/LCD overlay
// pattern generator and its sub-blocks.
// ----------------------------------------------------------------------------
package crtlo_pkg;

  localparam int COORD_W     = 12;
  localparam int SCALE_MAX   = 16;
  localparam int SCALE_W     = 5;
  localparam int REM_W       = $clog2(SCALE_MAX);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COORD_W-1:0] COORD_MAX = 12'd4095;
  localparam logic [SCALE_W-1:0] SCALE_HI  = SCALE_W'(SCALE_MAX);

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_SOFT   = 8'd181;
  localparam logic [7:0] ALPHA_GLOW   = 8'd170;
  localparam logic [7:0] ALPHA_LINE   = 8'd6;

  typedef enum logic [1:0] {
    MODE_GRILLE   = 2'd0,
    MODE_SCANLINE = 2'd1,
    MODE_GRID     = 2'd2,
    MODE_SLOT     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_SCALE = 2'd1,
    CFG_GRID  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
  } pipe_en_t;

  // Reciprocal of the scale, floor(2^RECIP_SHIFT / s).
  function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21845;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13107;
      5'd6:    r = 17'd10922;
      5'd7:    r = 17'd9362;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7281;
      5'd10:   r = 17'd6553;
      5'd11:   r = 17'd5957;
      5'd12:   r = 17'd5461;
      5'd13:   r = 17'd5041;
      5'd14:   r = 17'd4681;
      5'd15:   r = 17'd4369;
      5'd16:   r = 17'd4096;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Band of a position within its cell: (rem * 3) / s, which is below 3.
  function automatic logic [1:0] band_of(input logic [REM_W-1:0] rem,
                                         input logic [SCALE_W-1:0] s);
    logic [REM_W+1:0] t3;
    logic [1:0]       b;
    t3 = {2'b00, rem} + {1'b0, rem, 1'b0};
    if (t3 >= {s, 1'b0}) begin
      b = 2'd2;
    end else if (t3 >= {1'b0, s}) begin
      b = 2'd1;
    end else begin
      b = 2'd0;
    end
    return b;
  endfunction

  // Aperture grille tint tile; the outer rows are identical.
  function automatic pixel_t grille_px(input logic [1:0] row, input logic [1:0] col);
    pixel_t p;
    if (row == 2'd1) begin
      unique case (col)
        2'd0:    p = '{alpha: 8'd14, red: 8'd0,   green: 8'd252, blue: 8'd245};
        2'd1:    p = '{alpha: 8'd17, red: 8'd0,   green: 8'd0,   blue: 8'd243};
        default: p = '{alpha: 8'd28, red: 8'd236, green: 8'd1,   blue: 8'd0};
      endcase
    end else begin
      unique case (col)
        2'd0:    p = '{alpha: 8'd255, red: 8'd0, green: 8'd1, blue: 8'd1};
        2'd1:    p = '{alpha: 8'd255, red: 8'd1, green: 8'd0, blue: 8'd3};
        default: p = '{alpha: 8'd255, red: 8'd2, green: 8'd0, blue: 8'd0};
      endcase
    end
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/crtlo_modred.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crtlo_modred
// Three-stage reduction of one coordinate by the scale: reciprocal multiply
// for the quotient, back-multiply and one correction step for the remainder.
// ----------------------------------------------------------------------------
module crtlo_modred (
  input  wire                           clk,
  input  crtlo_pkg::pipe_en_t           en,
  input  wire [crtlo_pkg::COORD_W-1:0]  pos_in,
  input  wire [crtlo_pkg::RECIP_W-1:0]  recip_a,
  input  wire [crtlo_pkg::SCALE_W-1:0]  s_b,
  output logic [crtlo_pkg::REM_W-1:0]   rem_c,
  output logic                          q_odd_c
);
  import crtlo_pkg::*;

  localparam int PROD_W = COORD_W + RECIP_W;
  localparam int BACK_W = COORD_W + SCALE_W;

  logic [COORD_W-1:0] pos_a_r;
  logic [COORD_W-1:0] pos_b_r;
  logic [COORD_W-1:0] q_b_r;
  logic [COORD_W-1:0] q_b_nxt;
  logic [REM_W-1:0]   rem_c_r;
  logic [REM_W-1:0]   rem_c_nxt;
  logic               odd_c_r;
  logic               odd_c_nxt;
  logic [PROD_W-1:0]  prod;
  logic [BACK_W-1:0]  back;
  logic [COORD_W-1:0] r_est;
  logic [COORD_W-1:0] s_ext;

  always_comb begin
    prod    = PROD_W'(pos_a_r) * PROD_W'(recip_a);
    q_b_nxt = prod[COORD_W+RECIP_SHIFT-1:RECIP_SHIFT];
  end

  always_comb begin
    back  = BACK_W'(q_b_r) * BACK_W'(s_b);
    s_ext = COORD_W'(s_b);
    r_est = pos_b_r - back[COORD_W-1:0];
    if (r_est >= s_ext) begin
      rem_c_nxt = REM_W'(r_est - s_ext);
      odd_c_nxt = ~q_b_r[0];
    end else begin
      rem_c_nxt = REM_W'(r_est);
      odd_c_nxt = q_b_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_a) begin
      pos_a_r <= pos_in;
    end
    if (en.ld_b) begin
      pos_b_r <= pos_a_r;
      q_b_r   <= q_b_nxt;
    end
    if (en.ld_c) begin
      rem_c_r <= rem_c_nxt;
      odd_c_r <= odd_c_nxt;
    end
  end

  assign rem_c   = rem_c_r;
  assign q_odd_c = odd_c_r;

endmodule
`default_nettype wire

FILE: rtl/crtlo_shade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crtlo_shade
// Final stage: picks the overlay pixel of the selected effect from the cell
// offsets and registers it as the result.
// ----------------------------------------------------------------------------
module crtlo_shade (
  input  wire                           clk,
  input  wire                           ld,
  input  crtlo_pkg::mode_t              mode,
  input  wire [15:0]                    grid_color,
  input  wire [crtlo_pkg::SCALE_W-1:0]  s,
  input  wire                           in_frame,
  input  wire [crtlo_pkg::REM_W-1:0]    cx,
  input  wire [crtlo_pkg::REM_W-1:0]    cy,
  input  wire                           odd_row,
  output crtlo_pkg::pixel_t             pix
);
  import crtlo_pkg::*;

  pixel_t               pix_r;
  pixel_t               pix_nxt;
  logic [1:0]           band_x;
  logic [1:0]           band_y;
  logic [SCALE_W-1:0]   s_last;
  logic [SCALE_W-1:0]   cx_ext;
  logic [SCALE_W-1:0]   cy_ext;
  logic                 s_two;
  logic                 vborder;
  logic [7:0]           border_a;
  logic [4:0]           r5;
  logic [5:0]           g6;
  logic [4:0]           b5;

  always_comb begin
    band_x   = band_of(cx, s);
    band_y   = band_of(cy, s);
    s_last   = s - SCALE_W'(1);
    cx_ext   = SCALE_W'(cx);
    cy_ext   = SCALE_W'(cy);
    s_two    = (s == SCALE_W'(2));
    border_a = s_two ? ALPHA_SOFT : ALPHA_OPAQUE;
    vborder  = odd_row ? (cx_ext == s_last) : (cx == '0);
    r5       = grid_color[15:11];
    g6       = grid_color[10:5];
    b5       = grid_color[4:0];
    pix_nxt  = '0;
    if (in_frame) begin
      unique case (mode)
        MODE_GRILLE: begin
          pix_nxt = grille_px(band_y, band_x);
        end
        MODE_SCANLINE: begin
          pix_nxt.alpha = (band_y == 2'd1) ? ALPHA_LINE : ALPHA_OPAQUE;
        end
        MODE_GRID: begin
          pix_nxt.red   = {r5, r5[4:2]};
          pix_nxt.green = {g6, g6[5:4]};
          pix_nxt.blue  = {b5, b5[4:2]};
          if (s_two) begin
            pix_nxt.alpha = (cx_ext == SCALE_W'(1) && cy_ext == SCALE_W'(1)) ?
                            8'd0 : ALPHA_SOFT;
          end else begin
            pix_nxt.alpha = (cx == '0 || cy_ext == s_last) ? ALPHA_OPAQUE : 8'd0;
          end
        end
        default: begin
          if (cy == '0 || vborder) begin
            pix_nxt.alpha = border_a;
          end else if (cy_ext == SCALE_W'(1) && s >= SCALE_W'(3)) begin
            pix_nxt.alpha = ALPHA_GLOW;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule
`default_nettype wire

FILE: rtl/crt_lcd_overlay_pattern_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_lcd_overlay_pattern_generator
// Produces one ARGB8888 overlay pixel for each screen coordinate request.
//
// The input channel takes a request of pixel_x and pixel_y under valid and
// ready; the output channel returns the alpha, red, green and blue bytes of
// the pixel under valid and ready. Results come back in request order.
// The configuration port writes the effect mode, the scale and the grid
// color; write it only while no request is in flight.
// The datapath is four register stages: input capture with scale clamp and
// reciprocal lookup, quotient multiply, remainder correction, and effect
// selection into the output register. One request is taken every cycle
// while out_ready stays high.
// Each stage holds its request until the next one frees, so a stalled
// receiver fills empty stages first and then drops in_ready; nothing is lost
// or repeated. Reset empties the pipeline and sets mode 0, scale 3 and grid
// color 0.
// ----------------------------------------------------------------------------
module crt_lcd_overlay_pattern_generator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [crtlo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [crtlo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [crtlo_pkg::COORD_W-1:0]     in_pixel_x,
  input  wire [crtlo_pkg::COORD_W-1:0]     in_pixel_y,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [7:0]                       out_alpha,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue
);
  import crtlo_pkg::*;

  mode_t              mode_r;
  logic [SCALE_W-1:0] scale_r;
  logic [15:0]        grid_color_r;

  logic               v_a_r, v_b_r, v_c_r, v_d_r;
  logic               v_a_nxt, v_b_nxt, v_c_nxt, v_d_nxt;
  pipe_en_t           en;

  logic [SCALE_W-1:0] s_nxt;
  logic [SCALE_W-1:0] s_a_r, s_b_r, s_c_r;
  logic [RECIP_W-1:0] recip_a_r;
  logic               frame_nxt;
  logic               frame_a_r, frame_b_r, frame_c_r;

  logic [REM_W-1:0]   cx_c;
  logic [REM_W-1:0]   cy_c;
  logic               odd_x_c;
  logic               odd_y_c;
  pixel_t             pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_GRILLE;
      scale_r      <= SCALE_W'(3);
      grid_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r       <= mode_t'(cfg_wdata[1:0]);
        CFG_SCALE: scale_r      <= cfg_wdata[SCALE_W-1:0];
        CFG_GRID:  grid_color_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en.ld_d  = v_c_r && (!v_d_r || out_ready);
    en.ld_c  = v_b_r && (!v_c_r || en.ld_d);
    en.ld_b  = v_a_r && (!v_b_r || en.ld_c);
    in_ready = !v_a_r || en.ld_b;
    en.ld_a  = in_valid && in_ready;
    v_a_nxt  = en.ld_a || (v_a_r && !en.ld_b);
    v_b_nxt  = en.ld_b || (v_b_r && !en.ld_c);
    v_c_nxt  = en.ld_c || (v_c_r && !en.ld_d);
    v_d_nxt  = en.ld_d || (v_d_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
      v_d_r <= v_d_nxt;
    end
  end

  always_comb begin
    if (scale_r == '0) begin
      s_nxt = SCALE_W'(1);
    end else if (scale_r > SCALE_HI) begin
      s_nxt = SCALE_HI;
    end else begin
      s_nxt = scale_r;
    end
    frame_nxt = (in_pixel_x <= COORD_MAX) && (in_pixel_y <= COORD_MAX);
  end

  always_ff @(posedge clk) begin
    if (en.ld_a) begin
      s_a_r     <= s_nxt;
      recip_a_r <= recip_of(s_nxt);
      frame_a_r <= frame_nxt;
    end
    if (en.ld_b) begin
      s_b_r     <= s_a_r;
      frame_b_r <= frame_a_r;
    end
    if (en.ld_c) begin
      s_c_r     <= s_b_r;
      frame_c_r <= frame_b_r;
    end
  end

  crtlo_modred u_red_x (
    .clk     (clk),
    .en      (en),
    .pos_in  (in_pixel_x),
    .recip_a (recip_a_r),
    .s_b     (s_b_r),
    .rem_c   (cx_c),
    .q_odd_c (odd_x_c)
  );

  crtlo_modred u_red_y (
    .clk     (clk),
    .en      (en),
    .pos_in  (in_pixel_y),
    .recip_a (recip_a_r),
    .s_b     (s_b_r),
    .rem_c   (cy_c),
    .q_odd_c (odd_y_c)
  );

  crtlo_shade u_shade (
    .clk        (clk),
    .ld         (en.ld_d),
    .mode       (mode_r),
    .grid_color (grid_color_r),
    .s          (s_c_r),
    .in_frame   (frame_c_r),
    .cx         (cx_c),
    .cy         (cy_c),
    .odd_row    (odd_y_c),
    .pix        (pix)
  );

  assign out_valid = v_d_r;
  assign out_alpha = pix.alpha;
  assign out_red   = pix.red;
  assign out_green = pix.green;
  assign out_blue  = pix.blue;

  // The column quotient parity is not needed by any effect.
  logic unused_odd_x;
  assign unused_odd_x = odd_x_c;

endmodule
`default_nettype wire
